### hdl/ipm_pkg.sv
// Shared types and constants of the interval overlap pair matcher.
// Depends on nothing; every other file imports it.
package ipm_pkg;

    localparam int ID_W       = 32;
    localparam int KEY_W      = 32;
    localparam int COORD_W    = 16;
    localparam int SIZE_W     = 16;
    localparam int WEIGHT_W   = 17;
    localparam int LANE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int N_BOUNDS   = 7;
    localparam int DIV_STEPS  = WEIGHT_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);

    typedef struct packed {
        logic              start;
        logic [SIZE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [WEIGHT_W-1:0] quotient;
    } div_rsp_t;

endpackage

### hdl/ipm_ifs.sv
// Channel interfaces: input record, result pair and configuration write.
// Depends on ipm_pkg.
interface ipm_rec_if;
    import ipm_pkg::*;
    logic               valid;
    logic               ready;
    logic               from_second;
    logic [KEY_W-1:0]   group_key;
    logic [ID_W-1:0]    query_id;
    logic [COORD_W-1:0] span_start;
    logic [COORD_W-1:0] span_end;
    logic [SIZE_W-1:0]  query_size;
    modport source (output valid, from_second, group_key, query_id, span_start, span_end,
                    query_size, input ready);
    modport sink (input valid, from_second, group_key, query_id, span_start, span_end,
                  query_size, output ready);
endinterface

interface ipm_pair_if;
    import ipm_pkg::*;
    logic                valid;
    logic                ready;
    logic [ID_W-1:0]     low_id;
    logic [ID_W-1:0]     high_id;
    logic [WEIGHT_W-1:0] weight;
    logic [LANE_W-1:0]   lane;
    logic                overflow;
    logic                last;
    modport source (output valid, low_id, high_id, weight, lane, overflow, last, input ready);
    modport sink (input valid, low_id, high_id, weight, lane, overflow, last, output ready);
endinterface

interface ipm_cfg_if;
    import ipm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
    modport source (output valid, index, wdata, input ready);
    modport sink (input valid, index, wdata, output ready);
endinterface

### hdl/ipm_divider.sv
// Restoring divider: 65536 / divisor, one quotient bit per cycle.
// Depends on ipm_pkg.
module ipm_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  ipm_pkg::div_req_t req,
    output ipm_pkg::div_rsp_t rsp
);
    import ipm_pkg::*;

    logic [SIZE_W-1:0]    rem_reg;
    logic [WEIGHT_W-1:0]  quo_reg;
    logic [SIZE_W-1:0]    div_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [SIZE_W:0]      trial;
    logic [SIZE_W:0]      diff;

    assign trial = {rem_reg, quo_reg[WEIGHT_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= WEIGHT_ONE;
                div_reg  <= req.divisor;
            end
            else if (busy_reg)
            begin
                if (diff[SIZE_W])
                begin
                    rem_reg <= trial[SIZE_W-1:0];
                    quo_reg <= {quo_reg[WEIGHT_W-2:0], 1'b0};
                end
                else
                begin
                    rem_reg <= diff[SIZE_W-1:0];
                    quo_reg <= {quo_reg[WEIGHT_W-2:0], 1'b1};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### hdl/interval_overlap_pair_matcher.sv
// Top level: per-key record buffers, pair walk sequencer and result output.
// Depends on ipm_pkg, ipm_ifs and ipm_divider.
//
//  channel | dir | handshake   | carries
//  rec     | in  | valid/ready | one interval record
//  pair    | out | valid/ready | one matched pair, last marks the record's final pair
//  cfg     | in  | valid/ready | lane bound write, always ready
//
// For each record the walk reads and compares every buffered entry of the other source;
// a match goes through the weight divider, or skips it when a size is 0, and is then
// emitted.
// Reset clears counts, key, flags and lane bounds; buffers need no clearing.
// A stalled pair output holds the walk at the next match.
module interval_overlap_pair_matcher #(
    parameter int GROUP_DEPTH = 64,
    parameter int LANES       = 8
) (
    input logic     clk,
    input logic     rst_n,
    ipm_rec_if.sink   rec,
    ipm_pair_if.source pair,
    ipm_cfg_if.sink   cfg
);
    import ipm_pkg::*;

    localparam int CNT_W   = $clog2(GROUP_DEPTH + 1);
    localparam int IDX_W   = $clog2(GROUP_DEPTH);
    localparam int ENTRY_W = ID_W + 2 * COORD_W + SIZE_W;

    typedef enum logic [2:0] {ST_IDLE, ST_RD, ST_CMP, ST_DIV, ST_EMIT, ST_FIN} state_t;

    state_t                state_reg;
    logic [CFG_DATA_W-1:0] bound_reg [N_BOUNDS];
    logic [ENTRY_W-1:0]    mem_first  [GROUP_DEPTH];
    logic [ENTRY_W-1:0]    mem_second [GROUP_DEPTH];
    logic [ENTRY_W-1:0]    rd_first_reg;
    logic [ENTRY_W-1:0]    rd_second_reg;
    logic [CNT_W-1:0]      first_count_reg;
    logic [CNT_W-1:0]      second_count_reg;
    logic [KEY_W-1:0]      key_reg;
    logic                  key_valid_reg;
    logic                  sticky_reg;

    logic                  second_reg;
    logic [ID_W-1:0]       id_reg;
    logic [COORD_W-1:0]    start_reg;
    logic [COORD_W-1:0]    end_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic [CNT_W-1:0]      ocount_reg;
    logic [CNT_W-1:0]      k_reg;

    logic [ID_W-1:0]       res_lo_reg;
    logic [ID_W-1:0]       res_hi_reg;
    logic [WEIGHT_W-1:0]   res_w_reg;
    logic [LANE_W-1:0]     res_lane_reg;

    logic                  pend_valid_reg;
    logic [ID_W-1:0]       pend_lo_reg;
    logic [ID_W-1:0]       pend_hi_reg;
    logic [WEIGHT_W-1:0]   pend_w_reg;
    logic [LANE_W-1:0]     pend_lane_reg;

    logic                  out_valid_reg;
    logic [ID_W-1:0]       out_lo_reg;
    logic [ID_W-1:0]       out_hi_reg;
    logic [WEIGHT_W-1:0]   out_w_reg;
    logic [LANE_W-1:0]     out_lane_reg;
    logic                  out_ovf_reg;
    logic                  out_last_reg;

    div_req_t              div_req;
    div_rsp_t              div_rsp;

    logic                  rec_fire;
    logic                  new_key;
    logic [CNT_W-1:0]      fc_eff;
    logic [CNT_W-1:0]      sc_eff;
    logic [CNT_W-1:0]      own_cnt;
    logic                  own_full;
    logic [ENTRY_W-1:0]    wr_entry;
    logic                  out_free;
    logic                  out_load;
    logic                  k_last;

    logic [ENTRY_W-1:0]    ent;
    logic [ID_W-1:0]       e_id;
    logic [COORD_W-1:0]    e_start;
    logic [COORD_W-1:0]    e_end;
    logic [SIZE_W-1:0]     e_size;
    logic [COORD_W-1:0]    ov_hi;
    logic [COORD_W-1:0]    ov_lo;
    logic [COORD_W-1:0]    inter;
    logic [COORD_W-1:0]    u_hi;
    logic [COORD_W-1:0]    u_lo;
    logic signed [COORD_W:0] uni;
    logic [COORD_W+2:0]    uni4;
    logic [COORD_W+2:0]    inter5;
    logic                  is_match;
    logic [ID_W-1:0]       m_lo;
    logic [ID_W-1:0]       m_hi;
    logic [SIZE_W-1:0]     m_size;
    logic [LANE_W-1:0]     m_lane;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N_BOUNDS; i++)
            begin
                bound_reg[i] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            for (int i = 0; i < N_BOUNDS; i++)
            begin
                if (cfg.index == CFG_IDX_W'(i))
                begin
                    bound_reg[i] <= cfg.wdata;
                end
            end
        end
    end

    // record intake
    assign rec.ready = (state_reg == ST_IDLE);
    assign rec_fire  = rec.valid && rec.ready;
    assign new_key   = !key_valid_reg || (rec.group_key != key_reg);
    assign fc_eff    = new_key ? '0 : first_count_reg;
    assign sc_eff    = new_key ? '0 : second_count_reg;
    assign own_cnt   = rec.from_second ? sc_eff : fc_eff;
    assign own_full  = (own_cnt == CNT_W'(GROUP_DEPTH));
    assign wr_entry  = {rec.query_id, rec.span_start, rec.span_end, rec.query_size};

    always_ff @(posedge clk)
    begin
        if (rec_fire && !own_full && !rec.from_second)
        begin
            mem_first[own_cnt[IDX_W-1:0]] <= wr_entry;
        end
        if (state_reg == ST_RD)
        begin
            rd_first_reg <= mem_first[k_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_fire && !own_full && rec.from_second)
        begin
            mem_second[own_cnt[IDX_W-1:0]] <= wr_entry;
        end
        if (state_reg == ST_RD)
        begin
            rd_second_reg <= mem_second[k_reg[IDX_W-1:0]];
        end
    end

    // compare against one buffered entry
    assign ent     = second_reg ? rd_first_reg : rd_second_reg;
    assign e_id    = ent[ENTRY_W-1 -: ID_W];
    assign e_start = ent[2*COORD_W+SIZE_W-1 -: COORD_W];
    assign e_end   = ent[COORD_W+SIZE_W-1 -: COORD_W];
    assign e_size  = ent[SIZE_W-1:0];

    assign ov_hi    = (end_reg < e_end) ? end_reg : e_end;
    assign ov_lo    = (start_reg > e_start) ? start_reg : e_start;
    assign inter    = (ov_hi > ov_lo) ? (ov_hi - ov_lo) : '0;
    assign u_hi     = (end_reg > e_end) ? end_reg : e_end;
    assign u_lo     = (start_reg < e_start) ? start_reg : e_start;
    assign uni      = $signed({1'b0, u_hi}) - $signed({1'b0, u_lo});
    assign uni4     = {uni[COORD_W-1:0], 2'b00};
    assign inter5   = {inter, 2'b00} + {2'b00, inter};
    assign is_match = (uni > 0) && (uni4 < inter5);

    assign m_lo   = (id_reg < e_id) ? id_reg : e_id;
    assign m_hi   = (id_reg < e_id) ? e_id : id_reg;
    assign m_size = (size_reg < e_size) ? size_reg : e_size;

    always_comb
    begin
        m_lane = LANE_W'(LANES - 1);
        for (int i = LANES - 2; i >= 0; i--)
        begin
            if (i < N_BOUNDS && m_lo < bound_reg[i])
            begin
                m_lane = LANE_W'(i);
            end
        end
    end

    assign div_req.start   = (state_reg == ST_CMP) && is_match && (m_size != '0);
    assign div_req.divisor = m_size;

    ipm_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_free = !out_valid_reg || pair.ready;
    assign out_load = pend_valid_reg && out_free &&
                      ((state_reg == ST_EMIT) || (state_reg == ST_FIN));
    assign k_last   = (k_reg + 1'b1 == ocount_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            key_reg          <= '0;
            key_valid_reg    <= 1'b0;
            sticky_reg       <= 1'b0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            k_reg            <= '0;
            ocount_reg       <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pair.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (rec_fire)
                    begin
                        key_reg       <= rec.group_key;
                        key_valid_reg <= 1'b1;
                        if (rec.from_second)
                        begin
                            first_count_reg  <= fc_eff;
                            second_count_reg <= own_full ? sc_eff : sc_eff + 1'b1;
                        end
                        else
                        begin
                            first_count_reg  <= own_full ? fc_eff : fc_eff + 1'b1;
                            second_count_reg <= sc_eff;
                        end
                        if (own_full)
                        begin
                            sticky_reg <= 1'b1;
                        end
                        second_reg <= rec.from_second;
                        id_reg     <= rec.query_id;
                        start_reg  <= rec.span_start;
                        end_reg    <= rec.span_end;
                        size_reg   <= rec.query_size;
                        ocount_reg <= rec.from_second ? fc_eff : sc_eff;
                        k_reg      <= '0;
                        state_reg  <= ((rec.from_second ? fc_eff : sc_eff) == '0)
                                      ? ST_FIN : ST_RD;
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    res_lo_reg   <= m_lo;
                    res_hi_reg   <= m_hi;
                    res_lane_reg <= m_lane;
                    res_w_reg    <= WEIGHT_ONE;
                    if (!is_match)
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= k_last ? ST_FIN : ST_RD;
                    end
                    else
                    begin
                        state_reg <= (m_size == '0) ? ST_EMIT : ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        res_w_reg <= div_rsp.quotient;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_lo_reg    <= pend_lo_reg;
                            out_hi_reg    <= pend_hi_reg;
                            out_w_reg     <= pend_w_reg;
                            out_lane_reg  <= pend_lane_reg;
                            out_ovf_reg   <= sticky_reg;
                            out_last_reg  <= 1'b0;
                        end
                        pend_valid_reg <= 1'b1;
                        pend_lo_reg    <= res_lo_reg;
                        pend_hi_reg    <= res_hi_reg;
                        pend_w_reg     <= res_w_reg;
                        pend_lane_reg  <= res_lane_reg;
                        k_reg          <= k_reg + 1'b1;
                        state_reg      <= k_last ? ST_FIN : ST_RD;
                    end
                end
                ST_FIN:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_lo_reg     <= pend_lo_reg;
                        out_hi_reg     <= pend_hi_reg;
                        out_w_reg      <= pend_w_reg;
                        out_lane_reg   <= pend_lane_reg;
                        out_ovf_reg    <= sticky_reg;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign pair.valid    = out_valid_reg;
    assign pair.low_id   = out_lo_reg;
    assign pair.high_id  = out_hi_reg;
    assign pair.weight   = out_w_reg;
    assign pair.lane     = out_lane_reg;
    assign pair.overflow = out_ovf_reg;
    assign pair.last     = out_last_reg;

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        rec.ready |-> !pend_valid_reg)
        else $error("pending pair left behind at record start");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (first_count_reg <= CNT_W'(GROUP_DEPTH)) && (second_count_reg <= CNT_W'(GROUP_DEPTH)))
        else $error("buffer count beyond depth");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |-> (k_reg < ocount_reg))
        else $error("walk index beyond buffered entries");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside weight step");

endmodule

### sim/interval_overlap_pair_matcher_tb.sv
// Testbench for interval_overlap_pair_matcher: drives records, checks pairs against a
// behavioral predictor of the per-key buffers, lane bounds and weights.
// Depends on ipm_pkg, ipm_ifs and the block's RTL.
module interval_overlap_pair_matcher_tb;
    import ipm_pkg::*;

    localparam int DEPTH = 64;
    localparam int NLANES = 8;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic               from_second;
        logic [KEY_W-1:0]   group_key;
        logic [ID_W-1:0]    query_id;
        logic [COORD_W-1:0] span_start;
        logic [COORD_W-1:0] span_end;
        logic [SIZE_W-1:0]  query_size;
    } record_t;

    typedef struct packed {
        logic [ID_W-1:0]     low_id;
        logic [ID_W-1:0]     high_id;
        logic [WEIGHT_W-1:0] weight;
        logic [LANE_W-1:0]   lane;
        logic                overflow;
        logic                last;
    } pair_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ipm_rec_if  rec ();
    ipm_pair_if pair ();
    ipm_cfg_if  cfg ();

    interval_overlap_pair_matcher #(.GROUP_DEPTH(DEPTH), .LANES(NLANES)) u_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .rec  (rec.sink),
        .pair (pair.source),
        .cfg  (cfg.sink)
    );

    always #6 clk = ~clk;

    record_t record_queue[$];
    pair_t   expected_pairs[$];
    int      mismatches = 0;
    longint  cycle_count = 0;
    int      hold_off = 0;
    bit      sender_paused = 1'b0;
    bit      stim_done = 1'b0;
    int      send_gap = 0;
    int      recv_gap = 0;

    logic [31:0]  bounds[N_BOUNDS];
    logic [ID_W-1:0] buf_ids[2][DEPTH];
    logic [31:0]  buf_spans[2][DEPTH];
    logic [SIZE_W-1:0] buf_sizes[2][DEPTH];
    int           buf_count[2];
    logic [KEY_W-1:0] cur_key;
    bit           key_seen;
    bit           dropped;

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic bit spans_overlap(logic [31:0] a, logic [31:0] b);
        int as, ae, bs, be, hi, lo, inter, uni;
        as = a[31:16]; ae = a[15:0]; bs = b[31:16]; be = b[15:0];
        hi = ae < be ? ae : be;
        lo = as > bs ? as : bs;
        inter = hi > lo ? hi - lo : 0;
        uni = (ae > be ? ae : be) - (as < bs ? as : bs);
        if (uni <= 0) return 1'b0;
        return 4 * uni < 5 * inter;
    endfunction

    function automatic logic [LANE_W-1:0] route_lane(logic [ID_W-1:0] low);
        for (int k = 0; k < NLANES - 1 && k < N_BOUNDS; k++)
            if (low < bounds[k]) return LANE_W'(k);
        return LANE_W'(NLANES - 1);
    endfunction

    task automatic predict_pairs(record_t r);
        int own, other, ocount, first_new;
        logic [31:0] span;
        pair_t p;
        logic [SIZE_W-1:0] msz;
        if (!key_seen || r.group_key != cur_key) begin
            buf_count[0] = 0;
            buf_count[1] = 0;
            cur_key = r.group_key;
            key_seen = 1'b1;
        end
        own = r.from_second;
        other = 1 - own;
        ocount = buf_count[other];
        span = {r.span_start, r.span_end};
        if (buf_count[own] < DEPTH) begin
            buf_ids[own][buf_count[own]] = r.query_id;
            buf_spans[own][buf_count[own]] = span;
            buf_sizes[own][buf_count[own]] = r.query_size;
            buf_count[own]++;
        end else begin
            dropped = 1'b1;
        end
        first_new = expected_pairs.size();
        for (int k = 0; k < ocount; k++) begin
            if (spans_overlap(span, buf_spans[other][k])) begin
                p.low_id = r.query_id < buf_ids[other][k] ? r.query_id : buf_ids[other][k];
                p.high_id = r.query_id < buf_ids[other][k] ? buf_ids[other][k] : r.query_id;
                msz = r.query_size < buf_sizes[other][k] ? r.query_size : buf_sizes[other][k];
                p.weight = msz == 0 ? WEIGHT_ONE : WEIGHT_W'(32'd65536 / msz);
                p.lane = route_lane(p.low_id);
                p.overflow = dropped;
                p.last = 1'b0;
                expected_pairs.push_back(p);
            end
        end
        if (expected_pairs.size() > first_new)
            expected_pairs[expected_pairs.size() - 1].last = 1'b1;
    endtask

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rec.valid <= 1'b0;
            rec.from_second <= 1'b0;
            rec.group_key <= '0;
            rec.query_id <= '0;
            rec.span_start <= '0;
            rec.span_end <= '0;
            rec.query_size <= '0;
            send_gap <= 0;
        end else begin
            if (rec.valid && rec.ready)
                predict_pairs(record_queue.pop_front());
            if ((rec.valid && !rec.ready) || (rec.valid && rec.ready && send_gap == 0 &&
                record_queue.size() > 0 && !sender_paused)) begin
                if (rec.valid && rec.ready) begin
                    {rec.from_second, rec.group_key, rec.query_id, rec.span_start,
                     rec.span_end, rec.query_size} <= record_queue[0];
                    send_gap <= gap_length();
                end
            end else if (send_gap > 0) begin
                rec.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (record_queue.size() > 0 && !sender_paused) begin
                rec.valid <= 1'b1;
                {rec.from_second, rec.group_key, rec.query_id, rec.span_start,
                 rec.span_end, rec.query_size} <= record_queue[0];
                send_gap <= gap_length();
            end else begin
                rec.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n) begin
        pair_t got, want;
        if (!rst_n) begin
            pair.ready <= 1'b0;
            recv_gap <= 0;
        end else begin
            cycle_count <= cycle_count + 1;
            if (pair.valid && pair.ready) begin
                got = {pair.low_id, pair.high_id, pair.weight, pair.lane, pair.overflow,
                       pair.last};
                if (expected_pairs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected pair %h", got);
                end else begin
                    want = expected_pairs.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("pair mismatch: exp lo=%h hi=%h w=%h lane=%0d ov=%b last=%b",
                                     want.low_id, want.high_id, want.weight, want.lane,
                                     want.overflow, want.last,
                                     "\n              got lo=%h hi=%h w=%h lane=%0d ov=%b last=%b",
                                     got.low_id, got.high_id, got.weight, got.lane,
                                     got.overflow, got.last);
                    end
                end
            end
            if (hold_off > 0) begin
                pair.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                pair.ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                pair.ready <= 1'b1;
                if (pair.valid && pair.ready)
                    recv_gap <= gap_length();
            end
        end
    end

    // long receiver hold-off, counted in its own process
    always @(posedge clk) begin
        if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    always @(posedge clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_bound(int idx, logic [31:0] value);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= CFG_IDX_W'(idx);
        cfg.wdata <= value;
        do @(posedge clk); while (!cfg.ready);
        bounds[idx] = value;
        cfg.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (record_queue.size() > 0 || rec.valid || expected_pairs.size() > 0)
            @(posedge clk);
        repeat (2000) @(posedge clk);
    endtask

    task automatic add_record(bit src, logic [31:0] key, logic [31:0] id, int s, int e,
                              int sz);
        record_t r;
        r.from_second = src;
        r.group_key = key;
        r.query_id = id;
        r.span_start = COORD_W'(s);
        r.span_end = COORD_W'(e);
        r.query_size = SIZE_W'(sz);
        record_queue.push_back(r);
    endtask

    task automatic random_group(logic [31:0] key, int n, bit noise);
        int base, len, s;
        base = $urandom_range(0, 60000);
        len = $urandom_range(1, 5000);
        for (int i = 0; i < n; i++) begin
            if (noise && $urandom_range(0, 3) == 0) begin
                add_record($urandom_range(0, 1), key, $urandom, $urandom_range(0, 65535),
                           $urandom_range(0, 65535), $urandom_range(0, 65535));
            end else begin
                s = base + $urandom_range(0, len / 12);
                add_record($urandom_range(0, 1), key, $urandom, s,
                           s + len - $urandom_range(0, len / 12),
                           $urandom_range(0, 3) == 0 ? $urandom_range(0, 3)
                                                     : $urandom_range(1, 65535));
            end
        end
    endtask

    initial begin
        logic [31:0] key;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.wdata = '0;
        for (int i = 0; i < N_BOUNDS; i++) bounds[i] = '0;
        buf_count[0] = 0;
        buf_count[1] = 0;
        cur_key = '0;
        key_seen = 1'b0;
        dropped = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_BOUNDS; i++) write_bound(i, 32'(i + 1) << 28);

        // directed: extremes, sizes 0 and max, reversed spans, key decrease
        add_record(1'b0, 32'd10, 32'hFFFF_FFFF, 0, 65535, 0);
        add_record(1'b1, 32'd10, 32'h0000_0000, 0, 65535, 65535);
        add_record(1'b1, 32'd10, 32'h7000_0000, 100, 65535, 1);
        add_record(1'b0, 32'd10, 32'h1234_5678, 1000, 60000, 3);
        add_record(1'b0, 32'd10, 32'h5, 500, 100, 7);
        add_record(1'b1, 32'd10, 32'h6, 500, 100, 9);
        add_record(1'b1, 32'd10, 32'h7, 100, 100, 9);
        add_record(1'b0, 32'd3, 32'h8, 0, 10, 2);
        add_record(1'b1, 32'd3, 32'h9, 0, 10, 2);
        add_record(1'b1, 32'hFFFF_FFFF, 32'hA, 65535, 65535, 5);
        add_record(1'b0, 32'hFFFF_FFFF, 32'hB, 0, 9, 65535);
        add_record(1'b1, 32'hFFFF_FFFF, 32'hC, 1, 9, 65534);
        add_record(1'b0, 32'h0, 32'hD, 0, 100, 100);
        add_record(1'b1, 32'h0, 32'hE, 10, 95, 50);
        wait_drained();

        write_bound(0, 32'h0);
        write_bound(6, 32'hFFFF_FFFF);

        // overflow: fill one source beyond depth, then probe with the other
        for (int i = 0; i < DEPTH + 2; i++)
            add_record(1'b0, 32'd77, 32'(i), 200, 1200, i + 1);
        add_record(1'b1, 32'd77, 32'hFFFF_0000, 210, 1190, 40);
        hold_off = 600;
        wait_drained();

        for (int i = 0; i < N_BOUNDS; i++) write_bound(i, $urandom);
        key = 32'd100;
        for (int g = 0; g < 8; g++) begin
            key = ($urandom_range(0, 3) == 0) ? $urandom : key + $urandom_range(1, 50);
            random_group(key, $urandom_range(2, 6), g % 3 == 2);
        end
        while (record_queue.size() > 16) @(posedge clk);
        hold_off = 800;
        wait_drained();

        for (int i = 0; i < N_BOUNDS; i++) write_bound(i, 32'hFFFF_FFFF);
        for (int g = 0; g < 6; g++)
            random_group($urandom, $urandom_range(2, 4), g == 5);
        sender_paused = 1'b1;
        while (expected_pairs.size() > 0 || rec.valid) @(posedge clk);
        sender_paused = 1'b0;
        wait_drained();

        if (mismatches == 0 && expected_pairs.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
